// ===== rtl/ppcu_pkg.sv =====
package ppcu_pkg;

  // palette geometry
  localparam int PAL_BYTES   = 64;
  localparam int INDEX_LOW_W = 6;
  localparam int QUEUE_DEPTH = 2;

  // index register bits
  localparam int           AUTO_INC_BIT = 7;
  localparam logic [7:0]   INDEX_RD_SET = 8'h40;
  localparam logic [7:0]   UNUSED_RD    = 8'hFF;

  // reset values of the shade registers and object maps
  localparam logic [23:0]  MONO0_RST   = 24'hFFFFFF;
  localparam logic [23:0]  MONO1_RST   = 24'hAAAAAA;
  localparam logic [23:0]  MONO2_RST   = 24'h555555;
  localparam logic [23:0]  MONO3_RST   = 24'h000000;
  localparam logic [7:0]   OBJ_MAP_RST = 8'hFF;

  // stream widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_BG_INDEX  = 3'd0,
    SEL_BG_DATA   = 3'd1,
    SEL_OBJ_INDEX = 3'd2,
    SEL_OBJ_DATA  = 3'd3,
    SEL_BG_MONO   = 3'd4,
    SEL_OBJ_MONO0 = 3'd5,
    SEL_OBJ_MONO1 = 3'd6
  } sel_t;

  typedef enum logic [2:0] {
    CFG_COLOUR_MODE = 3'd0,
    CFG_BG_ENABLE   = 3'd1,
    CFG_MONO0       = 3'd2,
    CFG_MONO1       = 3'd3,
    CFG_MONO2       = 3'd4,
    CFG_MONO3       = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MAP_BG   = 2'd0,
    MAP_OBJ0 = 2'd1,
    MAP_OBJ1 = 2'd2
  } map_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef struct packed {
    logic             colour_mode;
    logic             bg_layer_en;
    logic [3:0][23:0] mono;
  } cfg_t;

  // one classified item as it waits between front and back
  typedef struct packed {
    cmd_t       op;
    sel_t       sel;
    logic [7:0] wdata;
    logic       colour;
    logic       pix_obj;
    map_t       map;
    logic [4:0] entry;
  } op_t;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

endpackage

// ===== rtl/ppcu_ram.sv =====
module ppcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ppcu_front.sv =====
module ppcu_front import ppcu_pkg::*; (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  cfg_t                 cfg,
  input  logic                 q_full,
  output logic                 push,
  output op_t                  push_op
);

  logic [2:0] sel;
  logic [7:0] wdata;
  logic [1:0] bg_id;
  logic [2:0] bg_pal;
  logic       sp_present;
  logic [1:0] sp_id;
  logic [2:0] sp_pal;
  logic       sp_behind;
  logic [1:0] bg_id_eff;
  logic       use_sprite;
  logic       known_cmd;

  assign sel        = in_tdata[2:0];
  assign wdata      = in_tdata[10:3];
  assign bg_id      = in_tdata[12:11];
  assign bg_pal     = in_tdata[15:13];
  assign sp_present = in_tdata[16];
  assign sp_id      = in_tdata[18:17];
  assign sp_pal     = in_tdata[21:19];
  assign sp_behind  = in_tdata[22];

  always_comb begin
    // monochrome with background off blanks the background colour
    bg_id_eff = (!cfg.colour_mode && !cfg.bg_layer_en) ? 2'd0 : bg_id;
    // master priority in colour mode overrides the normal sprite rule
    use_sprite = sp_present &&
                 ((cfg.colour_mode && cfg.bg_layer_en) ||
                  !((sp_id == 2'd0) || (sp_behind && (bg_id_eff != 2'd0))));
  end

  always_comb begin
    push_op.op      = cmd_t'(in_tuser);
    push_op.sel     = sel_t'(sel);
    push_op.wdata   = wdata;
    push_op.colour  = cfg.colour_mode;
    push_op.pix_obj = use_sprite;
    push_op.entry   = use_sprite ? {sp_pal, sp_id} : {bg_pal, bg_id_eff};
    if (!use_sprite) begin
      push_op.map = MAP_BG;
    end else if (sp_pal[0]) begin
      push_op.map = MAP_OBJ1;
    end else begin
      push_op.map = MAP_OBJ0;
    end
  end

  always_comb begin
    unique case (cmd_t'(in_tuser))
      CMD_WRITE, CMD_READ, CMD_PIXEL: known_cmd = 1'b1;
      default:                        known_cmd = 1'b0;
    endcase
  end

  // the unused command is taken and dropped here
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full && known_cmd;

endmodule

// ===== rtl/ppcu_queue.sv =====
module ppcu_queue import ppcu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic q_vld,
  output op_t  q_op
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_vld = (cnt_r != '0);
  assign q_op  = mem_r[rd_ptr_r];

endmodule

// ===== rtl/ppcu_back.sv =====
module ppcu_back import ppcu_pkg::*; #(
  parameter int PALETTE_BYTES = PAL_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  q_vld,
  input  op_t                   q_op,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int ADDR_W = $clog2(PALETTE_BYTES);
  localparam int PAIR_W = ADDR_W - 1;
  localparam int PAIRS  = PALETTE_BYTES / 2;

  // architectural state
  logic [7:0]               bg_index_r, bg_index_nxt;
  logic [7:0]               obj_index_r, obj_index_nxt;
  logic [7:0]               bg_map_r, bg_map_nxt;
  logic [7:0]               obj_map0_r, obj_map0_nxt;
  logic [7:0]               obj_map1_r, obj_map1_nxt;
  logic [PALETTE_BYTES-1:0] bg_vld_r, bg_vld_nxt;
  logic [PALETTE_BYTES-1:0] obj_vld_r, obj_vld_nxt;

  // issue stage
  logic        a_vld_r, a_vld_nxt;
  logic        a_pixel_r, a_ram_r, a_obj_r, a_odd_r, a_vlo_r, a_vhi_r;
  logic [7:0]  a_byte_r;
  logic [23:0] a_rgb_r;

  // output register
  logic                  out_vld_r, out_vld_nxt;
  logic                  out_kind_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic              a_adv;
  logic              is_wr, is_rd, is_pix;
  logic              bg_wr, obj_wr;
  logic [PAIR_W-1:0] bg_pair, obj_pair, use_pair;
  logic              use_obj;
  logic [PALETTE_BYTES-1:0] use_vld;
  logic              ram_re;
  logic [7:0]        bg_e_q, bg_o_q, obj_e_q, obj_o_q;
  logic              i_ram, i_odd, i_vlo, i_vhi;
  logic [7:0]        i_byte, sel_map;
  logic [1:0]        shade;
  logic [23:0]       i_rgb;
  logic [7:0]        lo, hi;
  logic [15:0]       pair_data;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign a_adv = a_vld_r && (!out_vld_r || out_tready);
  assign pop   = q_vld && (!a_vld_r || a_adv);

  assign is_wr  = (q_op.op == CMD_WRITE);
  assign is_rd  = (q_op.op == CMD_READ);
  assign is_pix = (q_op.op == CMD_PIXEL);

  assign bg_wr  = pop && is_wr && (q_op.sel == SEL_BG_DATA);
  assign obj_wr = pop && is_wr && (q_op.sel == SEL_OBJ_DATA);

  assign bg_pair  = is_pix ? q_op.entry[PAIR_W-1:0] : bg_index_r[ADDR_W-1:1];
  assign obj_pair = is_pix ? q_op.entry[PAIR_W-1:0] : obj_index_r[ADDR_W-1:1];
  assign ram_re   = pop && !is_wr;

  // each palette is split into even and odd byte banks so one read gets a colour pair
  ppcu_ram #(.WIDTH(8), .DEPTH(PAIRS)) u_bg_even (
    .clk(clk), .we(bg_wr && !bg_index_r[0]), .waddr(bg_index_r[ADDR_W-1:1]),
    .wdata(q_op.wdata), .re(ram_re), .raddr(bg_pair), .rdata(bg_e_q)
  );
  ppcu_ram #(.WIDTH(8), .DEPTH(PAIRS)) u_bg_odd (
    .clk(clk), .we(bg_wr && bg_index_r[0]), .waddr(bg_index_r[ADDR_W-1:1]),
    .wdata(q_op.wdata), .re(ram_re), .raddr(bg_pair), .rdata(bg_o_q)
  );
  ppcu_ram #(.WIDTH(8), .DEPTH(PAIRS)) u_obj_even (
    .clk(clk), .we(obj_wr && !obj_index_r[0]), .waddr(obj_index_r[ADDR_W-1:1]),
    .wdata(q_op.wdata), .re(ram_re), .raddr(obj_pair), .rdata(obj_e_q)
  );
  ppcu_ram #(.WIDTH(8), .DEPTH(PAIRS)) u_obj_odd (
    .clk(clk), .we(obj_wr && obj_index_r[0]), .waddr(obj_index_r[ADDR_W-1:1]),
    .wdata(q_op.wdata), .re(ram_re), .raddr(obj_pair), .rdata(obj_o_q)
  );

  // register writes and index auto-increment
  always_comb begin
    bg_index_nxt  = bg_index_r;
    obj_index_nxt = obj_index_r;
    bg_map_nxt    = bg_map_r;
    obj_map0_nxt  = obj_map0_r;
    obj_map1_nxt  = obj_map1_r;
    bg_vld_nxt    = bg_vld_r;
    obj_vld_nxt   = obj_vld_r;
    if (pop && is_wr) begin
      unique case (q_op.sel)
        SEL_BG_INDEX:  bg_index_nxt = q_op.wdata;
        SEL_BG_DATA: begin
          bg_vld_nxt[bg_index_r[ADDR_W-1:0]] = 1'b1;
          if (bg_index_r[AUTO_INC_BIT]) begin
            bg_index_nxt = {bg_index_r[7:INDEX_LOW_W],
                            bg_index_r[INDEX_LOW_W-1:0] + 1'b1};
          end
        end
        SEL_OBJ_INDEX: obj_index_nxt = q_op.wdata;
        SEL_OBJ_DATA: begin
          obj_vld_nxt[obj_index_r[ADDR_W-1:0]] = 1'b1;
          if (obj_index_r[AUTO_INC_BIT]) begin
            obj_index_nxt = {obj_index_r[7:INDEX_LOW_W],
                             obj_index_r[INDEX_LOW_W-1:0] + 1'b1};
          end
        end
        SEL_BG_MONO:   bg_map_nxt   = q_op.wdata;
        SEL_OBJ_MONO0: obj_map0_nxt = q_op.wdata;
        SEL_OBJ_MONO1: obj_map1_nxt = q_op.wdata;
        default: ;
      endcase
    end
  end

  // issue: pick palette, capture entry valid bits, resolve register reads and mono shades
  always_comb begin
    use_obj  = is_pix ? q_op.pix_obj : (q_op.sel == SEL_OBJ_DATA);
    use_pair = use_obj ? obj_pair : bg_pair;
    use_vld  = use_obj ? obj_vld_r : bg_vld_r;
    i_vlo    = use_vld[{use_pair, 1'b0}];
    i_vhi    = use_vld[{use_pair, 1'b1}];
    i_odd    = use_obj ? obj_index_r[0] : bg_index_r[0];
    i_ram    = (is_rd && ((q_op.sel == SEL_BG_DATA) || (q_op.sel == SEL_OBJ_DATA))) ||
               (is_pix && q_op.colour);

    unique case (q_op.sel)
      SEL_BG_INDEX:  i_byte = bg_index_r | INDEX_RD_SET;
      SEL_OBJ_INDEX: i_byte = obj_index_r | INDEX_RD_SET;
      SEL_BG_MONO:   i_byte = bg_map_r;
      SEL_OBJ_MONO0: i_byte = obj_map0_r;
      SEL_OBJ_MONO1: i_byte = obj_map1_r;
      default:       i_byte = UNUSED_RD;
    endcase

    unique case (q_op.map)
      MAP_BG:   sel_map = bg_map_r;
      MAP_OBJ0: sel_map = obj_map0_r;
      MAP_OBJ1: sel_map = obj_map1_r;
      default:  sel_map = bg_map_r;
    endcase
    shade = sel_map[{q_op.entry[1:0], 1'b0} +: 2];
    i_rgb = cfg.mono[shade];
  end

  always_comb begin
    if (pop && !is_wr) begin
      a_vld_nxt = 1'b1;
    end else if (a_adv) begin
      a_vld_nxt = 1'b0;
    end else begin
      a_vld_nxt = a_vld_r;
    end
    if (a_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // result formation from the registered palette data
  always_comb begin
    if (a_obj_r) begin
      lo = a_vlo_r ? obj_e_q : 8'd0;
      hi = a_vhi_r ? obj_o_q : 8'd0;
    end else begin
      lo = a_vlo_r ? bg_e_q : 8'd0;
      hi = a_vhi_r ? bg_o_q : 8'd0;
    end
    pair_data = {hi, lo};
    if (a_pixel_r) begin
      if (a_ram_r) begin
        out_data_nxt = {widen5(pair_data[14:10]), widen5(pair_data[9:5]),
                        widen5(pair_data[4:0]), 8'd0};
      end else begin
        out_data_nxt = {a_rgb_r[7:0], a_rgb_r[15:8], a_rgb_r[23:16], 8'd0};
      end
    end else begin
      out_data_nxt = {24'd0, a_ram_r ? (a_odd_r ? hi : lo) : a_byte_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_index_r  <= '0;
      obj_index_r <= '0;
      bg_map_r    <= '0;
      obj_map0_r  <= OBJ_MAP_RST;
      obj_map1_r  <= OBJ_MAP_RST;
      bg_vld_r    <= '0;
      obj_vld_r   <= '0;
      a_vld_r     <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      bg_index_r  <= bg_index_nxt;
      obj_index_r <= obj_index_nxt;
      bg_map_r    <= bg_map_nxt;
      obj_map0_r  <= obj_map0_nxt;
      obj_map1_r  <= obj_map1_nxt;
      bg_vld_r    <= bg_vld_nxt;
      obj_vld_r   <= obj_vld_nxt;
      a_vld_r     <= a_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      a_pixel_r <= is_pix;
      a_ram_r   <= i_ram;
      a_obj_r   <= use_obj;
      a_odd_r   <= i_odd;
      a_vlo_r   <= i_vlo;
      a_vhi_r   <= i_vhi;
      a_byte_r  <= i_byte;
      a_rgb_r   <= i_rgb;
    end
    if (a_adv) begin
      out_kind_r <= a_pixel_r ? KIND_PIXEL : KIND_READ;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  // auto-increment advances the low index bits and keeps the top two
  assert property (@(posedge clk) disable iff (!rst_n)
    bg_wr && bg_index_r[AUTO_INC_BIT] |=>
      (bg_index_r[INDEX_LOW_W-1:0] == $past(bg_index_r[INDEX_LOW_W-1:0]) + 1'b1) &&
      (bg_index_r[7:INDEX_LOW_W] == $past(bg_index_r[7:INDEX_LOW_W])))
    else $error("bg index auto-increment wrong");

  assert property (@(posedge clk) disable iff (!rst_n)
    obj_wr && !obj_index_r[AUTO_INC_BIT] |=> $stable(obj_index_r))
    else $error("obj index moved without auto-increment");

  // entry valid bits only ever set between resets
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((bg_vld_r & $past(bg_vld_r)) == $past(bg_vld_r)) &&
             ((obj_vld_r & $past(obj_vld_r)) == $past(obj_vld_r)))
    else $error("palette valid bit cleared");

  // a held issue stage must not be overwritten by a new pop
  assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && !a_adv |-> !pop)
    else $error("issue stage overrun");

endmodule

// ===== rtl/palette_pixel_colour_unit_core.sv =====
// Palette and pixel colour unit: holds the background and sprite colour palette RAMs
// (64 bytes each, written and read through an index register whose bit 7 selects
// auto-increment after a data write; index reads return bit 6 set), the three
// monochrome palette maps, and merges one background pixel with an optional sprite
// pixel into an RGB888 colour. Each input transaction carries a command in in_tuser
// (register write, register read or pixel); a write gives no result, a read or a pixel
// gives exactly one result transaction, tagged by out_tuser. Throughput is one
// transaction per clock sustained while out_tready is high: each palette is split
// into an even and an odd byte bank, so one read port per bank fetches a whole
// RGB555 entry. A result goes through the queue entry written at the accepting edge,
// the palette read issue register and the output register before it is offered.
// Configuration writes (mode, background enable, the four monochrome shades) are
// always accepted and must only be made while no transaction is in flight.
module palette_pixel_colour_unit_core import ppcu_pkg::*; #(
  parameter int PALETTE_BYTES = PAL_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_tuser,   // [1:0] command
  // [2:0] register_select, [10:3] write_data, [12:11] bg_colour_id,
  // [15:13] bg_palette_number, [16] sprite_present, [18:17] sprite_colour_id,
  // [21:19] sprite_palette_number, [22] sprite_behind_bg, [23] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tuser,  // [0] result_kind
  // [7:0] read_data, [15:8] red, [23:16] green, [31:24] blue
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, push, pop, q_vld;
  op_t  push_op, q_op;

  // configuration registers, writes to unlisted indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLOUR_MODE: cfg_nxt.colour_mode = cfg_data[0];
        CFG_BG_ENABLE:   cfg_nxt.bg_layer_en = cfg_data[0];
        CFG_MONO0:       cfg_nxt.mono[0]     = cfg_data;
        CFG_MONO1:       cfg_nxt.mono[1]     = cfg_data;
        CFG_MONO2:       cfg_nxt.mono[2]     = cfg_data;
        CFG_MONO3:       cfg_nxt.mono[3]     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.colour_mode <= 1'b0;
      cfg_r.bg_layer_en <= 1'b0;
      cfg_r.mono        <= {MONO3_RST, MONO2_RST, MONO1_RST, MONO0_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: decode and classify the pixel (sprite choice, palette entry)
  ppcu_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  // short queue lets the front keep taking transactions while the back stalls
  ppcu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_vld   (q_vld),
    .q_op    (q_op)
  );

  // back: register file, palette banks, colour expansion and output register
  ppcu_back #(.PALETTE_BYTES(PALETTE_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_vld      (q_vld),
    .q_op       (q_op),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== verif/tb_palette_pixel_colour_unit_core.sv =====
module tb_palette_pixel_colour_unit_core;
  import ppcu_pkg::*;

  // run shape
  localparam int          RAND_PER_PHASE = 205;
  localparam int          NUM_PHASES     = 6;
  localparam int          DRAIN_CYCLES   = 8;      // pipeline is three deep, a write leaves no trace
  localparam int          HOLD_AT        = 900;    // accepted commands before the long back-pressure
  localparam int          HOLD_CYCLES    = 300;
  localparam int          MAX_REPORTS    = 10;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  // one expected result transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] rd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_result_t;

  // predictor of the palette unit plus the queue of results it still owes
  class colour_scoreboard;
    logic           colour_mode;
    logic           bg_layer_en;
    logic [23:0]    shade [4];
    logic [7:0]     bg_idx;
    logic [7:0]     obj_idx;
    logic [7:0]     bg_ram [64];
    logic [7:0]     obj_ram [64];
    logic [7:0]     bg_map;
    logic [7:0]     obj_map [2];
    colour_result_t owed [$];
    int unsigned    mismatches;
    int unsigned    n_checked;
    int unsigned    n_writes;
    int unsigned    n_reads;
    int unsigned    n_pixels;
    int unsigned    n_ignored;
    int unsigned    n_settings;

    function new();
      colour_mode = 1'b0;
      bg_layer_en = 1'b0;
      shade[0]    = MONO0_RST;
      shade[1]    = MONO1_RST;
      shade[2]    = MONO2_RST;
      shade[3]    = MONO3_RST;
      bg_idx      = '0;
      obj_idx     = '0;
      for (int i = 0; i < 64; i++) begin
        bg_ram[i]  = '0;
        obj_ram[i] = '0;
      end
      bg_map     = '0;
      obj_map[0] = OBJ_MAP_RST;
      obj_map[1] = OBJ_MAP_RST;
      mismatches = 0;
      n_checked  = 0;
      n_writes   = 0;
      n_reads    = 0;
      n_pixels   = 0;
      n_ignored  = 0;
      n_settings = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [23:0] value);
      case (cfg_idx_t'(idx))
        CFG_COLOUR_MODE: colour_mode = value[0];
        CFG_BG_ENABLE:   bg_layer_en = value[0];
        CFG_MONO0:       shade[0]    = value;
        CFG_MONO1:       shade[1]    = value;
        CFG_MONO2:       shade[2]    = value;
        CFG_MONO3:       shade[3]    = value;
        default: ;
      endcase
    endfunction

    // 5-bit channel to 8 bits, low bits replicated from the top
    function logic [7:0] widen(logic [4:0] c);
      return {c, 3'b000} | 8'(c >> 2);
    endfunction

    // rgb555 entry (little endian byte pair) from one palette ram
    function logic [23:0] ram_rgb(logic obj, logic [2:0] pal, logic [1:0] id);
      logic [5:0]  a;
      logic [15:0] d;
      a = {pal, id, 1'b0};
      d = obj ? {obj_ram[a | 6'd1], obj_ram[a]} : {bg_ram[a | 6'd1], bg_ram[a]};
      return {widen(d[4:0]), widen(d[9:5]), widen(d[14:10])};
    endfunction

    function colour_result_t resolve_pixel(logic [1:0] bg_id, logic [2:0] bg_pal,
                                           logic sp_pres, logic [1:0] sp_id,
                                           logic [2:0] sp_pal, logic sp_beh);
      colour_result_t r;
      logic           use_obj;
      logic [23:0]    rgb;
      logic [7:0]     map;
      logic [1:0]     id;
      logic [7:0]     sh;
      // monochrome with the background off blanks the background colour
      if (!colour_mode && !bg_layer_en) bg_id = 2'd0;
      use_obj = 1'b0;
      if (sp_pres) begin
        // colour mode master priority: sprite always wins, even colour id zero
        if (colour_mode && bg_layer_en) use_obj = 1'b1;
        else use_obj = !(sp_id == 2'd0 || (sp_beh && bg_id != 2'd0));
      end
      if (colour_mode) begin
        rgb = use_obj ? ram_rgb(1'b1, sp_pal, sp_id) : ram_rgb(1'b0, bg_pal, bg_id);
      end else begin
        map = use_obj ? obj_map[sp_pal[0]] : bg_map;
        id  = use_obj ? sp_id : bg_id;
        sh  = map >> (2 * id);
        rgb = shade[sh[1:0]];
      end
      r       = '0;
      r.kind  = KIND_PIXEL;
      r.red   = rgb[23:16];
      r.green = rgb[15:8];
      r.blue  = rgb[7:0];
      return r;
    endfunction

    // one accepted input transaction
    function void note_command(logic [1:0] cmd, logic [22:0] f);
      logic [2:0]     sel;
      logic [7:0]     wd;
      colour_result_t r;
      sel = f[2:0];
      wd  = f[10:3];
      r   = '0;
      case (cmd_t'(cmd))
        CMD_WRITE: begin
          n_writes++;
          case (sel_t'(sel))
            SEL_BG_INDEX:  bg_idx = wd;
            SEL_BG_DATA: begin
              bg_ram[bg_idx[5:0]] = wd;
              if (bg_idx[AUTO_INC_BIT]) bg_idx[5:0] = bg_idx[5:0] + 6'd1;
            end
            SEL_OBJ_INDEX: obj_idx = wd;
            SEL_OBJ_DATA: begin
              obj_ram[obj_idx[5:0]] = wd;
              if (obj_idx[AUTO_INC_BIT]) obj_idx[5:0] = obj_idx[5:0] + 6'd1;
            end
            SEL_BG_MONO:   bg_map     = wd;
            SEL_OBJ_MONO0: obj_map[0] = wd;
            SEL_OBJ_MONO1: obj_map[1] = wd;
            default: ;
          endcase
        end
        CMD_READ: begin
          n_reads++;
          r.kind = KIND_READ;
          case (sel_t'(sel))
            SEL_BG_INDEX:  r.rd = bg_idx | INDEX_RD_SET;
            SEL_BG_DATA:   r.rd = bg_ram[bg_idx[5:0]];
            SEL_OBJ_INDEX: r.rd = obj_idx | INDEX_RD_SET;
            SEL_OBJ_DATA:  r.rd = obj_ram[obj_idx[5:0]];
            SEL_BG_MONO:   r.rd = bg_map;
            SEL_OBJ_MONO0: r.rd = obj_map[0];
            SEL_OBJ_MONO1: r.rd = obj_map[1];
            default:       r.rd = UNUSED_RD;
          endcase
          owed.push_back(r);
        end
        CMD_PIXEL: begin
          n_pixels++;
          owed.push_back(resolve_pixel(f[12:11], f[15:13], f[16], f[18:17], f[21:19], f[22]));
        end
        default: n_ignored++;
      endcase
    endfunction

    function void report(string what, logic [7:0] exp_v, logic [7:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %0s after %0d results: expected %02h, got %02h",
                 what, n_checked, exp_v, act_v);
    endfunction

    // one accepted result transaction
    function void check_result(logic kind, logic [31:0] d);
      colour_result_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with nothing owed: kind %0b data %08h", kind, d);
        return;
      end
      e = owed.pop_front();
      if (kind !== e.kind)       report("result kind", {7'd0, e.kind}, {7'd0, kind});
      if (d[7:0] !== e.rd)       report("read data", e.rd, d[7:0]);
      if (d[15:8] !== e.red)     report("red", e.red, d[15:8]);
      if (d[23:16] !== e.green)  report("green", e.green, d[23:16]);
      if (d[31:24] !== e.blue)   report("blue", e.blue, d[31:24]);
      n_checked++;
    endfunction

    function int pending_count();
      return owed.size();
    endfunction
  endclass

  // clock, reset and every block input start at a known value
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [1:0]            in_tuser   = '0;    // [1:0] command
  // [2:0] register_select, [10:3] write_data, [12:11] bg_colour_id,
  // [15:13] bg_palette_number, [16] sprite_present, [18:17] sprite_colour_id,
  // [21:19] sprite_palette_number, [22] sprite_behind_bg, [23] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  out_tuser;          // [0] result_kind
  // [7:0] read_data, [15:8] red, [23:16] green, [31:24] blue
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  colour_scoreboard sb;
  int                snd_idle_pct = 37;
  int                rcv_idle_pct = 64;
  logic              rcv_hold     = 1'b0;
  int                n_accepted   = 0;
  int unsigned       cycle_count  = 0;

  palette_pixel_colour_unit_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: a run that never drains ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results owed", cycle_count,
               sb.pending_count());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver ready changes on the falling edge; a hold keeps it low
  always @(negedge clk) begin
    if (rcv_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // every result transaction goes to the scoreboard at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // long back-pressure stretch while the sender keeps offering, so the block fills up
  initial begin
    wait (n_accepted >= HOLD_AT);
    @(posedge clk);
    rcv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rcv_hold = 1'b0;
  end

  // pack the input fields, select in the lowest bits
  function automatic logic [22:0] pack_fields(logic [2:0] sel, logic [7:0] wd,
                                              logic [1:0] bg_id, logic [2:0] bg_pal,
                                              logic sp_pres, logic [1:0] sp_id,
                                              logic [2:0] sp_pal, logic sp_beh);
    return {sp_beh, sp_pal, sp_id, sp_pres, bg_pal, bg_id, wd, sel};
  endfunction

  // offer one transaction, with random idle cycles ahead of it, until accepted
  task automatic push_command(logic [1:0] cmd, logic [22:0] f);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, f);
    n_accepted++;
  endtask

  // stop offering and let every owed result come out, then let writes settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(cfg_idx_t idx, logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_all(logic cm, logic be, logic [23:0] m0, logic [23:0] m1,
                             logic [23:0] m2, logic [23:0] m3);
    program_register(CFG_COLOUR_MODE, {23'd0, cm});
    program_register(CFG_BG_ENABLE, {23'd0, be});
    program_register(CFG_MONO0, m0);
    program_register(CFG_MONO1, m1);
    program_register(CFG_MONO2, m2);
    program_register(CFG_MONO3, m3);
    sb.n_settings++;
  endtask

  // mostly pixels, then writes, reads and the odd unused command
  function automatic logic [1:0] random_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 55) return CMD_PIXEL;
    if (r < 75) return CMD_WRITE;
    if (r < 93) return CMD_READ;
    return CMD_UNUSED;
  endfunction

  task automatic run_random(int count);
    int          i;
    int          burst;
    logic        obj;
    logic [22:0] f;
    i = 0;
    while (i < count) begin
      if ($urandom_range(99) < 8) begin
        // palette upload: index with auto-increment, then a run of data bytes
        obj   = 1'($urandom_range(1));
        f     = 23'($urandom);
        f[2:0]  = obj ? SEL_OBJ_INDEX : SEL_BG_INDEX;
        f[10:3] = 8'($urandom) | 8'h80;
        push_command(CMD_WRITE, f);
        burst = $urandom_range(10, 3);
        for (int k = 0; k < burst; k++) begin
          f      = 23'($urandom);
          f[2:0] = obj ? SEL_OBJ_DATA : SEL_BG_DATA;
          push_command(CMD_WRITE, f);
        end
        i += burst + 1;
      end else begin
        push_command(random_cmd(), 23'($urandom));
        i++;
      end
    end
  endtask

  task automatic run_directed();
    // every register read back at its reset value, unused select reads all ones
    for (int s = 0; s < 8; s++) push_command(CMD_READ, pack_fields(3'(s), 8'h00, 0, 0, 0, 0, 0, 0));
    // auto-increment from the top entry wraps to zero and keeps bits 7:6
    push_command(CMD_WRITE, pack_fields(SEL_BG_INDEX, 8'hBF, 0, 0, 0, 0, 0, 0));
    push_command(CMD_WRITE, pack_fields(SEL_BG_DATA, 8'h12, 0, 0, 0, 0, 0, 0));
    push_command(CMD_WRITE, pack_fields(SEL_BG_DATA, 8'hFF, 0, 0, 0, 0, 0, 0));
    push_command(CMD_READ, pack_fields(SEL_BG_INDEX, 8'h00, 0, 0, 0, 0, 0, 0));
    push_command(CMD_READ, pack_fields(SEL_BG_DATA, 8'h00, 0, 0, 0, 0, 0, 0));
    // plain index write, no increment, bit 6 forced on read
    push_command(CMD_WRITE, pack_fields(SEL_OBJ_INDEX, 8'h05, 0, 0, 0, 0, 0, 0));
    push_command(CMD_WRITE, pack_fields(SEL_OBJ_DATA, 8'hFF, 0, 0, 0, 0, 0, 0));
    push_command(CMD_READ, pack_fields(SEL_OBJ_INDEX, 8'h00, 0, 0, 0, 0, 0, 0));
    push_command(CMD_READ, pack_fields(SEL_OBJ_DATA, 8'h00, 0, 0, 0, 0, 0, 0));
    // unused select write is dropped, unused command gives nothing
    push_command(CMD_WRITE, pack_fields(3'd7, 8'hFF, 0, 0, 0, 0, 0, 0));
    push_command(CMD_UNUSED, 23'h7FFFFF);
    // monochrome, background off: background blanked, sprite behind still shows
    push_command(CMD_PIXEL, pack_fields(0, 0, 2'd3, 3'd7, 1'b0, 2'd0, 3'd0, 1'b0));
    push_command(CMD_PIXEL, pack_fields(0, 0, 2'd3, 3'd0, 1'b1, 2'd3, 3'd1, 1'b1));
    wait_idle();
    // colour mode with master priority: sprite id zero still wins
    program_all(1'b1, 1'b1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
    push_command(CMD_PIXEL, pack_fields(0, 0, 2'd3, 3'd7, 1'b1, 2'd0, 3'd1, 1'b1));
    push_command(CMD_PIXEL, pack_fields(0, 0, 2'd0, 3'd0, 1'b1, 2'd2, 3'd7, 1'b0));
    wait_idle();
    // colour mode without master priority: behind a nonzero background loses
    program_register(CFG_BG_ENABLE, 24'd0);
    push_command(CMD_PIXEL, pack_fields(0, 0, 2'd3, 3'd7, 1'b1, 2'd3, 3'd1, 1'b1));
    push_command(CMD_PIXEL, pack_fields(0, 0, 2'd0, 3'd7, 1'b1, 2'd1, 3'd1, 1'b1));
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      // idling pattern: sender light / receiver heavy, swapped, then none
      case (ph / 2)
        0: begin snd_idle_pct = 37; rcv_idle_pct = 64; end
        1: begin snd_idle_pct = 64; rcv_idle_pct = 37; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      case (ph)
        0: program_all(1'b0, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        1: program_all(1'b1, 1'b0, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        2: program_all(1'b1, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        3: program_all(1'b0, 1'b0, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        4: program_all(1'b0, 1'b1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
        default: program_all(1'b1, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom),
                             24'($urandom));
      endcase
      run_random(RAND_PER_PHASE);
    end

    wait_idle();
    $display("accepted %0d commands: %0d writes, %0d reads, %0d pixels, %0d unused",
             n_accepted, sb.n_writes, sb.n_reads, sb.n_pixels, sb.n_ignored);
    $display("checked %0d results over %0d register settings, %0d mismatches",
             sb.n_checked, sb.n_settings, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ppcu_pkg.sv
rtl/ppcu_ram.sv
rtl/ppcu_front.sv
rtl/ppcu_queue.sv
rtl/ppcu_back.sv
rtl/palette_pixel_colour_unit_core.sv
verif/tb_palette_pixel_colour_unit_core.sv
